// ----- rtl/core/lwkd_pkg.sv -----
// shared constants and payload types for the longest-window block
package lwkd_pkg;

  localparam int unsigned MAX_STRING = 4096;
  localparam int unsigned ADDR_W     = $clog2(MAX_STRING);
  localparam int unsigned LEN_W      = $clog2(MAX_STRING + 1);
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned NUM_SYM    = 256;
  localparam int unsigned DIST_W     = 9;
  localparam int unsigned OUT_LEN_W  = 13;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last_symbol;
  } in_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] longest_length;
    logic                 overflow;
  } out_t;

endpackage

// ----- rtl/core/lwkd_ram.sv -----
// simple dual-port ram, one write port, one registered read port
module lwkd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/longest_window_k_distinct.sv -----
// top level: longest window with at most max_distinct distinct bytes
//
//   channel | dir | handshake               | payload
//   --------+-----+-------------------------+-------------------------------
//   in      | in  | in_valid_i / in_ready_o  | in_data_i  (symbol, last flag)
//   out     | out | out_valid_o / out_ready_i| out_data_o (length, overflow)
//   cfg     | in  | cfg_we_i                 | cfg_wdata_i (max_distinct)
//
// a byte passes through accept, count update and window check, with no count update if
// the store is full; every byte dropped from the window start adds a store read, count
// read and count write, all through the count ram port and its +/-1 adder.
// reset clears the control registers and the per-value valid bits at once;
// the same valid bits all clear together at the end of each string.
// a final byte waits in the check state while an earlier result is unread.
module longest_window_k_distinct (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lwkd_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lwkd_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [lwkd_pkg::DIST_W-1:0]     cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CHECK,
    ST_OLD,
    ST_UPD
  } state_e;

  localparam int unsigned AW = lwkd_pkg::ADDR_W;
  localparam int unsigned LW = lwkd_pkg::LEN_W;
  localparam int unsigned DW = lwkd_pkg::DIST_W;
  localparam int unsigned SW = lwkd_pkg::SYM_W;

  state_e                      state_q;
  logic [DW-1:0]               max_q;
  logic [LW-1:0]               start_q;
  logic [LW-1:0]               end_q;
  logic [DW-1:0]               distinct_q;
  logic [LW-1:0]               best_q;
  logic                        ovf_q;
  logic                        skip_q;
  logic                        last_q;
  logic [SW-1:0]               sym_q;
  logic [lwkd_pkg::NUM_SYM-1:0] cnt_valid_q;
  logic                        out_valid_q;
  lwkd_pkg::out_t              out_data_q;

  // ram hookup
  logic            store_we;
  logic [SW-1:0]   store_rdata;
  logic            cnt_we;
  logic [SW-1:0]   cnt_waddr;
  logic [SW-1:0]   cnt_raddr;
  logic [LW-1:0]   cnt_rdata;
  logic [LW-1:0]   cnt_eff;
  logic [LW-1:0]   cnt_wdata;
  logic            accept;
  logic            room;
  logic            shrink;
  logic [LW-1:0]   win_len;
  logic [LW-1:0]   best_nx;
  logic            out_free;

  assign accept   = in_valid_i && in_ready_o;
  assign room     = end_q < LW'(lwkd_pkg::MAX_STRING);
  assign store_we = accept && room;
  assign out_free = !out_valid_q || out_ready_i;

  lwkd_ram #(
    .WIDTH (SW),
    .DEPTH (lwkd_pkg::MAX_STRING)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (end_q[AW-1:0]),
    .wdata_i (in_data_i.symbol),
    .raddr_i (start_q[AW-1:0]),
    .rdata_o (store_rdata)
  );

  // count ram: read on accept (new byte) or in ST_OLD (byte leaving)
  assign cnt_raddr = (state_q == ST_OLD) ? store_rdata : in_data_i.symbol;
  assign cnt_waddr = (state_q == ST_UPD) ? store_rdata : sym_q;
  assign cnt_eff   = cnt_valid_q[cnt_waddr] ? cnt_rdata : '0;

  // shared +/-1 unit on the count
  always_comb begin
    cnt_we    = 1'b0;
    cnt_wdata = cnt_eff + LW'(1);
    if (state_q == ST_ADD) begin
      cnt_we = 1'b1;
    end else if (state_q == ST_UPD) begin
      cnt_we    = (cnt_eff != '0);
      cnt_wdata = cnt_eff - LW'(1);
    end
  end

  lwkd_ram #(
    .WIDTH (LW),
    .DEPTH (lwkd_pkg::NUM_SYM)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign shrink  = !skip_q && (distinct_q > max_q) && (start_q < end_q);
  assign win_len = end_q - start_q;
  assign best_nx = (!skip_q && (distinct_q <= max_q) && (win_len > best_q)) ? win_len : best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      max_q       <= DW'(1);
      start_q     <= '0;
      end_q       <= '0;
      distinct_q  <= '0;
      best_q      <= '0;
      ovf_q       <= 1'b0;
      skip_q      <= 1'b0;
      last_q      <= 1'b0;
      sym_q       <= '0;
      cnt_valid_q <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            sym_q  <= in_data_i.symbol;
            last_q <= in_data_i.last_symbol;
            skip_q <= !room;
            if (room) begin
              state_q <= ST_ADD;
            end else begin
              ovf_q   <= 1'b1;
              state_q <= ST_CHECK;
            end
          end
        end
        ST_ADD: begin
          if (cnt_eff == '0) begin
            distinct_q <= distinct_q + DW'(1);
          end
          cnt_valid_q[sym_q] <= 1'b1;
          end_q              <= end_q + LW'(1);
          state_q            <= ST_CHECK;
        end
        ST_CHECK: begin
          if (shrink) begin
            state_q <= ST_OLD;
          end else if (!last_q) begin
            best_q  <= best_nx;
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q                <= 1'b1;
            out_data_q.longest_length  <= lwkd_pkg::OUT_LEN_W'(best_nx);
            out_data_q.overflow        <= ovf_q;
            // end of string: drop all per-string state
            cnt_valid_q <= '0;
            start_q     <= '0;
            end_q       <= '0;
            distinct_q  <= '0;
            best_q      <= '0;
            ovf_q       <= 1'b0;
            state_q     <= ST_IDLE;
          end else begin
            best_q <= best_nx;
          end
        end
        ST_OLD: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          if ((cnt_eff <= LW'(1)) && (distinct_q != '0)) begin
            distinct_q <= distinct_q - DW'(1);
          end
          start_q <= start_q + LW'(1);
          state_q <= ST_CHECK;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- tb/lwkd_checker.sv -----
// checker for the longest-window block: predicts each string's result and compares
module lwkd_checker
  import lwkd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_t               in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_t              out_data_i,
  input  logic              cfg_we_i,
  input  logic [DIST_W-1:0] cfg_wdata_i,
  output int                fail_count_o,
  output int                pending_o
);

  logic [LEN_W-1:0]  value_count [NUM_SYM];
  logic [SYM_W-1:0]  string_bytes [MAX_STRING];
  logic [LEN_W-1:0]  win_head;
  logic [LEN_W-1:0]  win_tail;
  logic [LEN_W-1:0]  best_len;
  logic [DIST_W-1:0] distinct_now;
  logic [DIST_W-1:0] limit_now;
  logic              store_overflowed;
  out_t              longest_q [$];
  out_t              want;

  function void clear_string_state();
    foreach (value_count[i]) value_count[i] = '0;
    win_head         = '0;
    win_tail         = '0;
    best_len         = '0;
    distinct_now     = '0;
    store_overflowed = 1'b0;
  endfunction

  // one byte of the string: grow the window, shrink from the start, track the best
  function void take_symbol(logic [SYM_W-1:0] sym, logic last);
    out_t             res;
    logic [SYM_W-1:0] gone;
    if (win_tail < MAX_STRING) begin
      string_bytes[win_tail[ADDR_W-1:0]] = sym;
      if (value_count[sym] == 0) distinct_now++;
      value_count[sym]++;
      win_tail++;
      while (distinct_now > limit_now && win_head < win_tail) begin
        gone = string_bytes[win_head[ADDR_W-1:0]];
        if (value_count[gone] != 0) value_count[gone]--;
        if (value_count[gone] == 0 && distinct_now != 0) distinct_now--;
        win_head++;
      end
      if (distinct_now <= limit_now && LEN_W'(win_tail - win_head) > best_len)
        best_len = win_tail - win_head;
    end else begin
      store_overflowed = 1'b1;
    end
    if (last) begin
      res.longest_length = best_len;
      res.overflow       = store_overflowed;
      longest_q.push_back(res);
      clear_string_state();
    end
  endfunction

  // everything changes at the rising edge, so the falling edge sees settled handshakes
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_now = 9'd1;
      clear_string_state();
      longest_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) limit_now = cfg_wdata_i;
      if (in_valid_i && in_ready_i)
        take_symbol(in_data_i.symbol, in_data_i.last_symbol);
      if (out_valid_i && out_ready_i) begin
        if (longest_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, got length %0d overflow %0b",
                   $time, out_data_i.longest_length, out_data_i.overflow);
          fail_count_o++;
        end else begin
          want = longest_q.pop_front();
          if (out_data_i.longest_length !== want.longest_length) begin
            $display("%0t: longest_length mismatch: expected %0d, got %0d",
                     $time, want.longest_length, out_data_i.longest_length);
            fail_count_o++;
          end
          if (out_data_i.overflow !== want.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, got %0b",
                     $time, want.overflow, out_data_i.overflow);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = longest_q.size();
  end

endmodule

// ----- tb/tb.sv -----
// testbench top: drives strings and limit settings into the longest-window block
module tb;
  import lwkd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned PHASE_ITEMS    = 150;
  localparam int unsigned NUM_PHASES     = 10;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  in_t               in_data   = '0;
  logic              out_ready = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [DIST_W-1:0] cfg_wdata = '0;
  logic              in_ready;
  logic              out_valid;
  out_t              out_data;
  bit                no_idling = 1'b0;
  int                fail_count;
  int                pending;

  longest_window_k_distinct DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  lwkd_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random bursts of stall and ready, steady ready at the end
  initial begin
    @(posedge clk_i);
    forever begin
      if (no_idling) begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(negedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_run = 0;
      else idle_run++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // one request; returns at the edge that accepts it
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
    if (!no_idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{symbol: sym, last_symbol: last};
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
  endtask

  // limit changes only once the block has drained
  task automatic set_limit(input logic [DIST_W-1:0] k);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // a string drawn from a shuffled alphabet, with runs of repeats; noisy uses any byte
  task automatic send_string(input int len, input int alpha_size, input bit noisy);
    logic [SYM_W-1:0] alpha [NUM_SYM];
    logic [SYM_W-1:0] sym;
    logic [SYM_W-1:0] swap;
    int               j;
    for (int i = 0; i < NUM_SYM; i++) alpha[i] = SYM_W'(i);
    for (int i = NUM_SYM - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      swap     = alpha[i];
      alpha[i] = alpha[j];
      alpha[j] = swap;
    end
    sym = alpha[0];
    for (int i = 0; i < len; i++) begin
      if (noisy) sym = SYM_W'($urandom);
      else if (i == 0 || $urandom_range(0, 1) == 0)
        sym = alpha[$urandom_range(0, alpha_size - 1)];
      send_symbol(sym, i == len - 1);
    end
  endtask

  initial begin
    logic [DIST_W-1:0] phase_limit [NUM_PHASES];
    int                sent;
    int                len;
    int                eff;
    int                lo;
    int                hi;

    phase_limit = '{9'd1, 9'd2, 9'd3, 9'd0, 9'd256, 9'd511, 9'd257,
                    DIST_W'($urandom_range(4, 16)), DIST_W'($urandom_range(1, 256)),
                    DIST_W'($urandom_range(0, 511))};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset limit of one
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(8'h00, 1'b1);
    // zero limit empties the window every byte
    set_limit(9'd0);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h80, 1'b1);
    set_limit(9'd2);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'h02, 1'b0);
    send_symbol(8'h01, 1'b0);
    send_symbol(8'h03, 1'b0);
    send_symbol(8'h03, 1'b0);
    send_symbol(8'h03, 1'b1);
    // limit above the number of byte values
    set_limit(9'd511);
    send_symbol(8'h55, 1'b0);
    send_symbol(8'hAA, 1'b0);
    send_symbol(8'h0F, 1'b0);
    send_symbol(8'hF0, 1'b1);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_limit(phase_limit[p]);
      if (p == NUM_PHASES - 1) no_idling = 1'b1;
      eff = (phase_limit[p] > 256) ? 256 : int'(phase_limit[p]);
      lo  = (eff > 2) ? eff - 2 : 1;
      hi  = (eff == 0) ? 4 : ((eff + 3 > 256) ? 256 : eff + 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
        send_string(len, $urandom_range(lo, hi), $urandom_range(0, 9) == 0);
        sent += len;
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
